// ===== rtl/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding window maximum package
// Shared constants and types for the sliding window maximum block.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int CFG_W           = 7;

    localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd3;

    typedef struct packed {
        logic accept;
        logic flush;
        logic shift;
    } cell_ctrl_t;

endpackage

// ===== rtl/swm_in_if.sv =====
// ----------------------------------------------------------------------------
// Sample stream interface
// Valid/ready channel that carries one sample beat with its framing flags.
// ----------------------------------------------------------------------------
interface swm_in_if #(
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          start_of_stream;
    logic                          last_sample;

    modport source (
        output valid, sample, start_of_stream, last_sample,
        input  ready
    );

    modport sink (
        input  valid, sample, start_of_stream, last_sample,
        output ready
    );
endinterface

// ===== rtl/swm_out_if.sv =====
// ----------------------------------------------------------------------------
// Window maximum result interface
// Valid/ready channel that carries one result beat.
// ----------------------------------------------------------------------------
interface swm_out_if #(
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] window_max;
    logic                          last_of_stream;

    modport source (
        output valid, window_max, last_of_stream,
        input  ready
    );

    modport sink (
        input  valid, window_max, last_of_stream,
        output ready
    );
endinterface

// ===== rtl/sliding_window_maximum.sv =====
// ----------------------------------------------------------------------------
// Sliding window maximum
// Streams signed samples and reports the maximum of the last window_size.
// ----------------------------------------------------------------------------
// The block takes one sample beat per clock cycle while no result is held
// back and, once window_size samples of the current stream have arrived,
// returns one result beat per sample, in the cycle after the sample is taken.
// Candidates live in a row of MAX_WINDOW cells that all compare against the
// new sample in the same cycle and shift toward the front in one step, so the
// rate is one sample per cycle whenever the result side takes its beats.
module sliding_window_maximum #(
    parameter int MAX_WINDOW  = swm_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [swm_pkg::CFG_W-1:0] cfg_wdata,
    swm_in_if.sink                    samples,
    swm_out_if.source                 results
);
    import swm_pkg::*;

    localparam int POS_MOD = 2 * MAX_WINDOW;
    localparam int POS_W   = $clog2(POS_MOD);
    localparam int CMP_W   = (POS_W > CFG_W) ? POS_W : CFG_W;

    logic [CFG_W-1:0] window_reg;
    logic [POS_W-1:0] position_reg;
    logic [POS_W-1:0] position_next;
    logic [CMP_W-1:0] seen_reg;
    logic [CMP_W-1:0] seen_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             last_reg;

    logic             accept;
    logic             flush;
    logic             stale;
    logic [CMP_W-1:0] window_raw;
    logic [CMP_W-1:0] window_eff;
    logic [POS_W-1:0] position_eff;
    logic [POS_W:0]   age_diff;
    logic [POS_W-1:0] age;
    logic [CMP_W-1:0] seen_eff;
    cell_ctrl_t       ctrl;

    logic                          cell_keep  [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]         cell_valid;
    logic signed [SAMPLE_BITS-1:0] cell_value [MAX_WINDOW];
    logic        [POS_W-1:0]       cell_pos   [MAX_WINDOW];

    assign samples.ready = !out_valid_reg || results.ready;
    assign accept        = samples.valid && samples.ready;
    assign flush         = samples.start_of_stream;

    always_comb
    begin
        window_raw = CMP_W'(window_reg);
        if (window_raw == '0)
        begin
            window_eff = CMP_W'(1);
        end
        else if (window_raw > CMP_W'(MAX_WINDOW))
        begin
            window_eff = CMP_W'(MAX_WINDOW);
        end
        else
        begin
            window_eff = window_raw;
        end
    end

    always_comb
    begin
        position_eff = flush ? '0 : position_reg;
        age_diff     = {1'b0, position_eff} - {1'b0, cell_pos[0]};
        if (age_diff[POS_W])
        begin
            age = POS_W'(age_diff + (POS_W + 1)'(POS_MOD));
        end
        else
        begin
            age = age_diff[POS_W-1:0];
        end
        stale = cell_valid[0] && !flush && (CMP_W'(age) >= window_eff);

        if (position_eff == POS_W'(POS_MOD - 1))
        begin
            position_next = '0;
        end
        else
        begin
            position_next = position_eff + POS_W'(1);
        end

        seen_eff = flush ? '0 : seen_reg;
        if (seen_eff < window_eff)
        begin
            seen_next = seen_eff + CMP_W'(1);
        end
        else
        begin
            seen_next = seen_eff;
        end

        ctrl.accept = accept;
        ctrl.flush  = flush;
        ctrl.shift  = stale || cell_keep[MAX_WINDOW-1];

        out_valid_next = out_valid_reg && !results.ready;
        if (accept)
        begin
            out_valid_next = (seen_next >= window_eff);
        end
    end

    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        logic                          prev_keep;
        logic                          next_keep;
        logic signed [SAMPLE_BITS-1:0] next_value;
        logic        [POS_W-1:0]       next_pos;

        if (i == 0)
        begin : g_head
            assign prev_keep = 1'b1;
        end
        else
        begin : g_body
            assign prev_keep = cell_keep[i-1];
        end

        if (i == MAX_WINDOW - 1)
        begin : g_tail
            assign next_keep  = 1'b0;
            assign next_value = cell_value[i];
            assign next_pos   = cell_pos[i];
        end
        else
        begin : g_link
            assign next_keep  = cell_keep[i+1];
            assign next_value = cell_value[i+1];
            assign next_pos   = cell_pos[i+1];
        end

        swm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .POS_W       (POS_W),
            .HEAD        (i == 0)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .sample     (samples.sample),
            .position   (position_eff),
            .prev_keep  (prev_keep),
            .next_keep  (next_keep),
            .next_value (next_value),
            .next_pos   (next_pos),
            .keep       (cell_keep[i]),
            .valid      (cell_valid[i]),
            .value      (cell_value[i]),
            .pos        (cell_pos[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= WINDOW_RESET;
            position_reg  <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
            end
            if (accept)
            begin
                position_reg <= position_next;
                seen_reg     <= seen_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last_reg <= samples.last_sample;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.window_max     = cell_value[0];
    assign results.last_of_stream = last_reg;

    // The occupied cells always form a contiguous run from the front.
    a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((cell_valid >> 1) & ~cell_valid) == '0)
        else $error("candidate cells are not contiguous");

    // Every taken sample leaves at least one candidate behind.
    a_front: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> cell_valid[0])
        else $error("queue empty after a sample beat");

    // A stream start leaves only the new sample in the queue.
    a_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && flush) |=> !cell_valid[1])
        else $error("queue not cleared at stream start");

    // A result beat is never offered while the queue is empty.
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> cell_valid[0])
        else $error("result beat without a candidate");

endmodule

// ===== rtl/swm_cell.sv =====
// ----------------------------------------------------------------------------
// Candidate cell
// One slot of the monotonic candidate queue. It compares its value with the
// incoming sample, then keeps its entry, takes its right neighbor's entry,
// or takes the new sample, or becomes empty.
// ----------------------------------------------------------------------------
module swm_cell #(
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
    parameter int POS_W       = 8,
    parameter bit HEAD        = 1'b0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  swm_pkg::cell_ctrl_t           ctrl,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic        [POS_W-1:0]       position,
    input  logic                          prev_keep,
    input  logic                          next_keep,
    input  logic signed [SAMPLE_BITS-1:0] next_value,
    input  logic        [POS_W-1:0]       next_pos,
    output logic                          keep,
    output logic                          valid,
    output logic signed [SAMPLE_BITS-1:0] value,
    output logic        [POS_W-1:0]       pos
);
    import swm_pkg::*;

    logic                          valid_reg;
    logic                          valid_next;
    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic signed [SAMPLE_BITS-1:0] value_next;
    logic        [POS_W-1:0]       pos_reg;
    logic        [POS_W-1:0]       pos_next;
    logic                          src_keep;
    logic                          left_keep;

    assign keep = valid_reg && !ctrl.flush && (value_reg > sample);

    always_comb
    begin
        src_keep   = ctrl.shift ? next_keep : keep;
        left_keep  = ctrl.shift ? (keep || HEAD) : prev_keep;
        valid_next = valid_reg;
        value_next = value_reg;
        pos_next   = pos_reg;
        if (ctrl.accept)
        begin
            if (src_keep)
            begin
                valid_next = 1'b1;
                if (ctrl.shift)
                begin
                    value_next = next_value;
                    pos_next   = next_pos;
                end
            end
            else if (left_keep)
            begin
                valid_next = 1'b1;
                value_next = sample;
                pos_next   = position;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        pos_reg   <= pos_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign pos   = pos_reg;

endmodule
